// ===== src/sdfts_pkg.sv =====
// shared constants and types for the sdf grid trilinear sampler
// no dependencies

package sdfts_pkg;

    localparam int MAX_DIM_X_DEF   = 64;
    localparam int MAX_DIM_Y_DEF   = 64;
    localparam int MAX_DIM_Z_DEF   = 64;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;

    localparam int GUARD   = 6;
    localparam int IDX_W   = 6;
    localparam int SIZE_W  = 7;
    localparam int POS_W   = 32;
    localparam int DIMS_W  = 18;
    localparam int VAL_W   = 16;
    localparam int CFG_W   = 32;
    localparam int CFG_IW  = 3;
    localparam int LATENCY = 11;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    typedef enum logic [CFG_IW-1:0] {
        CFG_DIMS    = 3'd0,
        CFG_ORG_X   = 3'd1,
        CFG_ORG_Y   = 3'd2,
        CFG_ORG_Z   = 3'd3,
        CFG_SCALE_X = 3'd4,
        CFG_SCALE_Y = 3'd5,
        CFG_SCALE_Z = 3'd6
    } t_cfg_idx;

endpackage

// ===== src/sdfts_ram.sv =====
// generic single-port ram with registered read
// no dependencies

module sdfts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32768,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_q <= r_mem[i_addr];
    end

    assign o_rdata = r_q;

endmodule

// ===== src/sdfts_axis.sv =====
// per-axis position to grid index and weight, three register stages
// depends on sdfts_pkg

module sdfts_axis
    import sdfts_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic signed [POS_W-1:0] i_pos,
    input  logic signed [POS_W-1:0] i_org,
    input  logic [POS_W-1:0]        i_scale,
    input  logic [SIZE_W-1:0]       i_size,
    output logic [IDX_W-1:0]        o_i0,
    output logic [IDX_W-1:0]        o_i1,
    output logic [FRAC_BITS-1:0]    o_u
);

    logic signed [POS_W:0]  n_diff;
    logic                   r_neg1;
    logic [POS_W-1:0]       r_mag;
    logic                   r_neg2;
    logic [2*POS_W-1:0]     r_g;
    logic [POS_W-1:0]       w_ip;
    logic [SIZE_W-1:0]      w_last;
    logic [IDX_W-1:0]       r_i0;
    logic [IDX_W-1:0]       r_i1;
    logic [FRAC_BITS-1:0]   r_u;

    assign n_diff = (POS_W+1)'(i_pos) - (POS_W+1)'(i_org);
    assign w_ip   = r_g[2*POS_W-1:POS_W];
    assign w_last = i_size - SIZE_W'(1);

    always_ff @(posedge i_clk) begin
        r_neg1 <= n_diff[POS_W];
        r_mag  <= n_diff[POS_W] ? POS_W'(-n_diff) : POS_W'(n_diff);
        r_neg2 <= r_neg1;
        r_g    <= (2*POS_W)'(r_mag) * (2*POS_W)'(i_scale);
        if (r_neg2 && (r_g != '0)) begin
            r_i0 <= '0;
            r_i1 <= '0;
            r_u  <= '0;
        end else if (w_ip >= POS_W'(w_last)) begin
            r_i0 <= IDX_W'(w_last);
            r_i1 <= IDX_W'(w_last);
            r_u  <= '0;
        end else begin
            r_i0 <= w_ip[IDX_W-1:0];
            r_i1 <= w_ip[IDX_W-1:0] + IDX_W'(1);
            r_u  <= r_g[POS_W-1 -: FRAC_BITS];
        end
    end

    assign o_i0 = r_i0;
    assign o_i1 = r_i1;
    assign o_u  = r_u;

endmodule

// ===== src/sdfts_lerp.sv =====
// two-stage linear blend: weighted products, then sum with round half up
// depends on nothing

module sdfts_lerp #(
    parameter int IW    = 16,
    parameter int OW    = 23,
    parameter int FW    = 16,
    parameter int SHIFT = 10
) (
    input  logic                 i_clk,
    input  logic signed [IW-1:0] i_a,
    input  logic signed [IW-1:0] i_b,
    input  logic [FW-1:0]        i_wt,
    output logic signed [OW-1:0] o_res
);

    localparam int PW = IW + FW + 2;
    localparam int SW = PW + 1;
    localparam logic signed [SW-1:0] HALF = SW'(1) <<< (SHIFT - 1);

    logic [FW:0]            w_wa;
    logic signed [PW-1:0]   r_pa;
    logic signed [PW-1:0]   r_pb;
    logic signed [SW-1:0]   n_sum;
    logic signed [OW-1:0]   r_res;

    assign w_wa  = {1'b1, {FW{1'b0}}} - {1'b0, i_wt};
    assign n_sum = SW'(r_pa) + SW'(r_pb) + HALF;

    always_ff @(posedge i_clk) begin
        r_pa <= PW'(i_a) * $signed({1'b0, w_wa});
        // zero weight masks the upper corner entirely
        r_pb <= (i_wt == '0) ? '0 : PW'(i_b) * $signed({1'b0, i_wt});
        r_res <= OW'(n_sum >>> SHIFT);
    end

    assign o_res = r_res;

endmodule

// ===== src/sdf_grid_trilinear_sampler_core.sv =====
// each accepted sample beat gives one result strobe; write beats give no result
// throughput: one beat per cycle, busy is always low, the receiver cannot stall
// reset clears the pipeline valid bits and the config registers; the voxel
// store (eight banks by index parity) is not cleared
// depends on sdfts_pkg, sdfts_axis, sdfts_lerp, sdfts_ram

module sdf_grid_trilinear_sampler_core
    import sdfts_pkg::*;
#(
    parameter int MAX_DIM_X   = MAX_DIM_X_DEF,
    parameter int MAX_DIM_Y   = MAX_DIM_Y_DEF,
    parameter int MAX_DIM_Z   = MAX_DIM_Z_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic                    i_cfg_we,
    input  logic [CFG_IW-1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0]        i_cfg_data,
    input  logic                    i_command,
    input  logic [IDX_W-1:0]        i_voxel_x,
    input  logic [IDX_W-1:0]        i_voxel_y,
    input  logic [IDX_W-1:0]        i_voxel_z,
    input  logic signed [VAL_W-1:0] i_voxel_value,
    input  logic signed [POS_W-1:0] i_pos_x,
    input  logic signed [POS_W-1:0] i_pos_y,
    input  logic signed [POS_W-1:0] i_pos_z,
    output logic                    o_valid,
    output logic signed [VAL_W-1:0] o_distance
);

    localparam int HX    = (MAX_DIM_X + 1) / 2;
    localparam int HY    = (MAX_DIM_Y + 1) / 2;
    localparam int HZ    = (MAX_DIM_Z + 1) / 2;
    localparam int BDEP  = HX * HY * HZ;
    localparam int BAW   = (BDEP > 1) ? $clog2(BDEP) : 1;
    localparam int SB    = SAMPLE_BITS;
    localparam int CW    = SAMPLE_BITS + GUARD + 1;
    localparam logic signed [CW:0] HALF_G = (CW+1)'(1) <<< (GUARD - 1);
    localparam logic signed [CW:0] SAT_HI = (CW+1)'(32767);
    localparam logic signed [CW:0] SAT_LO = -(CW+1)'(32768);

    // config registers
    logic [DIMS_W-1:0]       r_dims;
    logic signed [POS_W-1:0] r_org_x, r_org_y, r_org_z;
    logic [POS_W-1:0]        r_scl_x, r_scl_y, r_scl_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dims  <= '0;
            r_org_x <= '0;
            r_org_y <= '0;
            r_org_z <= '0;
            r_scl_x <= POS_W'(65536);
            r_scl_y <= POS_W'(65536);
            r_scl_z <= POS_W'(65536);
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DIMS:    r_dims  <= i_cfg_data[DIMS_W-1:0];
                CFG_ORG_X:   r_org_x <= i_cfg_data;
                CFG_ORG_Y:   r_org_y <= i_cfg_data;
                CFG_ORG_Z:   r_org_z <= i_cfg_data;
                CFG_SCALE_X: r_scl_x <= i_cfg_data;
                CFG_SCALE_Y: r_scl_y <= i_cfg_data;
                CFG_SCALE_Z: r_scl_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [SIZE_W-1:0] w_dx, w_dy, w_dz, w_sx, w_sy, w_sz;

    assign w_dx = {1'b0, r_dims[IDX_W-1:0]} + SIZE_W'(1);
    assign w_dy = {1'b0, r_dims[2*IDX_W-1:IDX_W]} + SIZE_W'(1);
    assign w_dz = {1'b0, r_dims[3*IDX_W-1:2*IDX_W]} + SIZE_W'(1);
    assign w_sx = (w_dx > SIZE_W'(MAX_DIM_X)) ? SIZE_W'(MAX_DIM_X) : w_dx;
    assign w_sy = (w_dy > SIZE_W'(MAX_DIM_Y)) ? SIZE_W'(MAX_DIM_Y) : w_dy;
    assign w_sz = (w_dz > SIZE_W'(MAX_DIM_Z)) ? SIZE_W'(MAX_DIM_Z) : w_dz;

    assign busy = 1'b0;

    // beat control and write fields, aligned with the axis stages
    logic [2:0]               r_avld;
    logic [2:0]               r_acmd;
    logic [IDX_W-1:0]         r_wx [3];
    logic [IDX_W-1:0]         r_wy [3];
    logic [IDX_W-1:0]         r_wz [3];
    logic signed [SB-1:0]     r_wval [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avld <= '0;
        end else begin
            r_avld <= {r_avld[1:0], start && !busy};
        end
        r_acmd    <= {r_acmd[1:0], i_command};
        r_wx[0]   <= i_voxel_x;
        r_wy[0]   <= i_voxel_y;
        r_wz[0]   <= i_voxel_z;
        r_wval[0] <= SB'(i_voxel_value);
        for (int s = 1; s < 3; s++) begin
            r_wx[s]   <= r_wx[s-1];
            r_wy[s]   <= r_wy[s-1];
            r_wz[s]   <= r_wz[s-1];
            r_wval[s] <= r_wval[s-1];
        end
    end

    logic [IDX_W-1:0]     w_x0, w_x1, w_y0, w_y1, w_z0, w_z1;
    logic [FRAC_BITS-1:0] w_u, w_v, w_w;

    sdfts_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
        .i_clk(i_clk), .i_pos(i_pos_x), .i_org(r_org_x), .i_scale(r_scl_x),
        .i_size(w_sx), .o_i0(w_x0), .o_i1(w_x1), .o_u(w_u)
    );
    sdfts_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
        .i_clk(i_clk), .i_pos(i_pos_y), .i_org(r_org_y), .i_scale(r_scl_y),
        .i_size(w_sy), .o_i0(w_y0), .o_i1(w_y1), .o_u(w_v)
    );
    sdfts_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_z (
        .i_clk(i_clk), .i_pos(i_pos_z), .i_org(r_org_z), .i_scale(r_scl_z),
        .i_size(w_sz), .o_i0(w_z0), .o_i1(w_z1), .o_u(w_w)
    );

    logic w_is_wr;
    logic w_wr_ok;

    assign w_is_wr = r_avld[2] && (r_acmd[2] == CMD_WRITE);
    assign w_wr_ok = w_is_wr && ({1'b0, r_wx[2]} < w_sx) && ({1'b0, r_wy[2]} < w_sy)
                     && ({1'b0, r_wz[2]} < w_sz);

    // eight parity banks
    logic signed [SB-1:0] w_q [8];

    for (genvar k = 0; k < 8; k++) begin : g_bank
        localparam logic PX = 1'((k >> 0) & 1);
        localparam logic PY = 1'((k >> 1) & 1);
        localparam logic PZ = 1'((k >> 2) & 1);

        logic [IDX_W-1:0] w_ax, w_ay, w_az, w_ix, w_iy, w_iz;
        logic [BAW-1:0]   w_addr;
        logic             w_we;
        logic [SB-1:0]    w_rd;

        assign w_ax = (w_x0[0] == PX) ? w_x0 : w_x1;
        assign w_ay = (w_y0[0] == PY) ? w_y0 : w_y1;
        assign w_az = (w_z0[0] == PZ) ? w_z0 : w_z1;
        assign w_ix = w_is_wr ? r_wx[2] : w_ax;
        assign w_iy = w_is_wr ? r_wy[2] : w_ay;
        assign w_iz = w_is_wr ? r_wz[2] : w_az;
        assign w_addr = BAW'((w_iz >> 1) * (HX * HY) + (w_iy >> 1) * HX + (w_ix >> 1));
        assign w_we = w_wr_ok && (r_wx[2][0] == PX) && (r_wy[2][0] == PY)
                      && (r_wz[2][0] == PZ);

        sdfts_ram #(.WIDTH(SB), .DEPTH(BDEP), .AW(BAW)) u_ram (
            .i_clk(i_clk), .i_we(w_we), .i_addr(w_addr),
            .i_wdata(r_wval[2]), .o_rdata(w_rd)
        );

        assign w_q[k] = $signed(w_rd);
    end

    // read stage, aligned with bank data
    logic                 r_rvld;
    logic [FRAC_BITS-1:0] r_ru, r_rv, r_rw;
    logic                 r_rx0p, r_ry0p, r_rz0p;
    logic [FRAC_BITS-1:0] r_vd [2];
    logic [FRAC_BITS-1:0] r_wd [4];
    logic [6:0]           r_pvld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvld <= 1'b0;
            r_pvld <= '0;
        end else begin
            r_rvld <= r_avld[2] && (r_acmd[2] == CMD_SAMPLE);
            r_pvld <= {r_pvld[5:0], r_rvld};
        end
        r_ru   <= w_u;
        r_rv   <= w_v;
        r_rw   <= w_w;
        r_rx0p <= w_x0[0];
        r_ry0p <= w_y0[0];
        r_rz0p <= w_z0[0];
        r_vd[0] <= r_rv;
        r_vd[1] <= r_vd[0];
        r_wd[0] <= r_rw;
        for (int s = 1; s < 4; s++) begin
            r_wd[s] <= r_wd[s-1];
        end
    end

    // x blend of four corner pairs
    logic signed [CW-1:0] w_cx [4];

    for (genvar c = 0; c < 4; c++) begin : g_xl
        localparam logic CY = 1'(c & 1);
        localparam logic CZ = 1'((c >> 1) & 1);

        logic [2:0] w_ka, w_kb;

        assign w_ka = {r_rz0p ^ CZ, r_ry0p ^ CY, r_rx0p};
        assign w_kb = {r_rz0p ^ CZ, r_ry0p ^ CY, ~r_rx0p};

        sdfts_lerp #(.IW(SB), .OW(CW), .FW(FRAC_BITS), .SHIFT(FRAC_BITS - GUARD)) u_lx (
            .i_clk(i_clk), .i_a(w_q[w_ka]), .i_b(w_q[w_kb]), .i_wt(r_ru),
            .o_res(w_cx[c])
        );
    end

    logic signed [CW-1:0] w_c0, w_c1, w_cz;

    sdfts_lerp #(.IW(CW), .OW(CW), .FW(FRAC_BITS), .SHIFT(FRAC_BITS)) u_ly0 (
        .i_clk(i_clk), .i_a(w_cx[0]), .i_b(w_cx[1]), .i_wt(r_vd[1]), .o_res(w_c0)
    );
    sdfts_lerp #(.IW(CW), .OW(CW), .FW(FRAC_BITS), .SHIFT(FRAC_BITS)) u_ly1 (
        .i_clk(i_clk), .i_a(w_cx[2]), .i_b(w_cx[3]), .i_wt(r_vd[1]), .o_res(w_c1)
    );
    sdfts_lerp #(.IW(CW), .OW(CW), .FW(FRAC_BITS), .SHIFT(FRAC_BITS)) u_lz (
        .i_clk(i_clk), .i_a(w_c0), .i_b(w_c1), .i_wt(r_wd[3]), .o_res(w_cz)
    );

    // drop guard bits and saturate
    logic signed [CW:0]      n_r;
    logic signed [VAL_W-1:0] r_dist;

    assign n_r = ((CW+1)'(w_cz) + HALF_G) >>> GUARD;

    always_ff @(posedge i_clk) begin
        if (n_r > SAT_HI) begin
            r_dist <= VAL_W'(SAT_HI);
        end else if (n_r < SAT_LO) begin
            r_dist <= VAL_W'(SAT_LO);
        end else begin
            r_dist <= VAL_W'(n_r);
        end
    end

    assign o_valid    = r_pvld[6];
    assign o_distance = r_dist;

endmodule

// ===== src/sdfts_checker.sv =====
// port-level checks for the sampler core, bound to the top level
// depends on sdfts_pkg

module sdfts_checker
    import sdfts_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic i_command,
    input logic o_valid
);

    logic w_samp;

    assign w_samp = start && !busy && (i_command == CMD_SAMPLE);

    a_sample_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_samp |-> ##LATENCY o_valid)
        else $error("sample beat gave no result");

    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_samp, LATENCY))
        else $error("result without a sample beat");

    a_reset_quiet: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result strobe right after reset");

endmodule

bind sdf_grid_trilinear_sampler_core sdfts_checker u_sdfts_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .start(start),
    .busy(busy),
    .i_command(i_command),
    .o_valid(o_valid)
);

// ===== tb/sv/tb_top.sv =====
// testbench for sdf_grid_trilinear_sampler_core: voxel writes, config phases and
// trilinear point queries checked against an in-bench predictor of the sampler
// depends on sdfts_pkg and the sampler rtl
`timescale 1ns / 1ps

module tb_top;
    import sdfts_pkg::*;

    typedef struct {
        logic                    cmd;
        logic [IDX_W-1:0]        vx, vy, vz;
        logic signed [VAL_W-1:0] val;
        logic signed [POS_W-1:0] px, py, pz;
    } beat_t;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    start = 1'b0;
    logic                    busy;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IW-1:0]       i_cfg_idx = '0;
    logic [CFG_W-1:0]        i_cfg_data = '0;
    logic                    i_command = CMD_WRITE;
    logic [IDX_W-1:0]        i_voxel_x = '0, i_voxel_y = '0, i_voxel_z = '0;
    logic signed [VAL_W-1:0] i_voxel_value = '0;
    logic signed [POS_W-1:0] i_pos_x = '0, i_pos_y = '0, i_pos_z = '0;
    logic                    o_valid;
    logic signed [VAL_W-1:0] o_distance;

    sdf_grid_trilinear_sampler_core DUT (.*);

    initial forever #6 i_clk = ~i_clk;

    // predictor state
    logic [DIMS_W-1:0]       grid_dims;
    logic signed [POS_W-1:0] grid_org [3];
    logic [31:0]             grid_scl [3];
    logic signed [VAL_W-1:0] voxel_mem [int];
    logic signed [VAL_W-1:0] distance_q [$];
    int                      n_fail = 0;
    int                      n_mism = 0;
    bit                      burst = 1'b0;

    function automatic int axis_len(int k);
        return int'(grid_dims[6*k +: 6]) + 1;
    endfunction

    function automatic int voxel_addr(int x, int y, int z);
        return (z * 64 + y) * 64 + x;
    endfunction

    function automatic void map_axis(input logic signed [31:0] p, input logic signed [31:0] o,
                                     input logic [31:0] s, input int n,
                                     output int i0, output int i1, output longint w);
        longint          d;
        longint unsigned mag, g;
        d = longint'(p) - longint'(o);
        mag = (d < 0) ? longint'(-d) : d;
        g = mag * longint'({32'd0, s});
        if (d < 0 && g != 0) begin
            i0 = 0; i1 = 0; w = 0;
        end else if ((g >> 32) >= longint'(n - 1)) begin
            i0 = n - 1; i1 = n - 1; w = 0;
        end else begin
            i0 = int'(g >> 32); i1 = i0 + 1; w = longint'(g[31:16]);
        end
    endfunction

    function automatic longint round_down(longint c, int s);
        return (c + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint blend(longint a, longint b, longint w, int s);
        return round_down(a * (65536 - w) + b * w, s);
    endfunction

    // returns 0 if a corner voxel was never written
    function automatic bit predict_distance(beat_t b, output logic signed [VAL_W-1:0] r);
        int     xi [2], yi [2], zi [2];
        longint u, v, w, c [2][2], cz [2], acc;
        map_axis(b.px, grid_org[0], grid_scl[0], axis_len(0), xi[0], xi[1], u);
        map_axis(b.py, grid_org[1], grid_scl[1], axis_len(1), yi[0], yi[1], v);
        map_axis(b.pz, grid_org[2], grid_scl[2], axis_len(2), zi[0], zi[1], w);
        for (int j = 0; j < 2; j++)
            for (int k = 0; k < 2; k++)
                for (int i = 0; i < 2; i++)
                    if (!voxel_mem.exists(voxel_addr(xi[i], yi[j], zi[k]))) return 1'b0;
        for (int j = 0; j < 2; j++)
            for (int k = 0; k < 2; k++)
                c[j][k] = blend(voxel_mem[voxel_addr(xi[0], yi[j], zi[k])],
                                voxel_mem[voxel_addr(xi[1], yi[j], zi[k])], u, 16 - GUARD);
        for (int k = 0; k < 2; k++) cz[k] = blend(c[0][k], c[1][k], v, 16);
        acc = round_down(blend(cz[0], cz[1], w, 16), GUARD);
        if (acc > 32767) acc = 32767;
        if (acc < -32768) acc = -32768;
        r = acc[15:0];
        return 1'b1;
    endfunction

    // entered and left at a falling edge
    task automatic send_beat(beat_t b);
        logic signed [VAL_W-1:0] r;
        int                      gap;
        if (b.cmd == CMD_SAMPLE) begin
            if (!predict_distance(b, r)) begin
                start <= 1'b0;
                return;
            end
            distance_q.push_back(r);
        end else if (int'(b.vx) < axis_len(0) && int'(b.vy) < axis_len(1)
                     && int'(b.vz) < axis_len(2)) begin
            voxel_mem[voxel_addr(b.vx, b.vy, b.vz)] = b.val;
        end
        gap = burst ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_command <= b.cmd; i_voxel_x <= b.vx; i_voxel_y <= b.vy; i_voxel_z <= b.vz;
        i_voxel_value <= b.val; i_pos_x <= b.px; i_pos_y <= b.py; i_pos_z <= b.pz;
        start <= 1'b1;
        @(negedge i_clk);
        while (busy) @(negedge i_clk);
    endtask

    task automatic drain;
        int n;
        n = 0;
        start <= 1'b0;
        @(negedge i_clk);
        while (distance_q.size() != 0 && n < 100000) begin
            @(negedge i_clk);
            n++;
        end
        if (distance_q.size() != 0) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            repeat (LATENCY + 4) @(negedge i_clk);
        end
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] d);
        case (idx)
            CFG_DIMS:    grid_dims = d[DIMS_W-1:0];
            CFG_ORG_X:   grid_org[0] = d;
            CFG_ORG_Y:   grid_org[1] = d;
            CFG_ORG_Z:   grid_org[2] = d;
            CFG_SCALE_X: grid_scl[0] = d;
            CFG_SCALE_Y: grid_scl[1] = d;
            CFG_SCALE_Z: grid_scl[2] = d;
            default: ;
        endcase
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= d;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic setup_grid(int nx, int ny, int nz, logic [31:0] o [3], logic [31:0] s [3]);
        drain();
        write_reg(CFG_DIMS, 32'((nz - 1) << 12 | (ny - 1) << 6 | (nx - 1)));
        write_reg(CFG_ORG_X, o[0]); write_reg(CFG_ORG_Y, o[1]); write_reg(CFG_ORG_Z, o[2]);
        write_reg(CFG_SCALE_X, s[0]); write_reg(CFG_SCALE_Y, s[1]); write_reg(CFG_SCALE_Z, s[2]);
    endtask

    function automatic beat_t voxel_beat(int x, int y, int z, logic [15:0] val);
        beat_t b;
        b = '{CMD_WRITE, x[5:0], y[5:0], z[5:0], val, $urandom, $urandom, $urandom};
        return b;
    endfunction

    function automatic beat_t query_beat(logic [31:0] x, logic [31:0] y, logic [31:0] z);
        beat_t b;
        b = '{CMD_SAMPLE, $urandom, $urandom, $urandom, $urandom, x, y, z};
        return b;
    endfunction

    // position that lands near the grid, from about one voxel below it to about two beyond its last voxel
    function automatic logic [31:0] aim_axis(int k);
        longint gq;
        if (grid_scl[k] == 0) return $urandom;
        gq = longint'($urandom_range(0, (axis_len(k) + 2) * 65536)) - 65536;
        return 32'(longint'(grid_org[k]) + (gq <<< 16) / longint'({32'd0, grid_scl[k]}));
    endfunction

    task automatic fill_grid();
        burst = ($urandom_range(0, 3) != 0);
        for (int z = 0; z < axis_len(2); z++)
            for (int y = 0; y < axis_len(1); y++)
                for (int x = 0; x < axis_len(0); x++)
                    send_beat(voxel_beat(x, y, z, $urandom));
        burst = 1'b0;
    endtask

    task automatic test_single_voxel();
        logic [31:0] o [3] = '{0, 0, 0};
        logic [31:0] s [3] = '{32'h10000, 32'h10000, 32'h10000};
        send_beat(voxel_beat(0, 0, 0, 16'h7FFF));
        send_beat(voxel_beat(1, 0, 0, 16'h8000));
        send_beat(query_beat(32'h7FFFFFFF, 32'h80000000, 0));
        send_beat(voxel_beat(0, 0, 0, 16'h8000));
        send_beat(query_beat(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF));
        setup_grid(2, 2, 2, o, s);
        fill_grid();
        send_beat(query_beat(32'h8000, 32'h8000, 32'h8000));
        send_beat(query_beat(32'h0FFFF, 32'h10000, 32'h0));
        send_beat(query_beat(32'hFFFFFFFF, 32'h18000, 32'h4000));
    endtask

    task automatic test_full_dims();
        logic [31:0] o [3] = '{32'h80000000, 32'h80000000, 32'h80000000};
        logic [31:0] s [3] = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF};
        setup_grid(64, 64, 64, o, s);
        send_beat(voxel_beat(63, 63, 63, 16'h8000));
        send_beat(voxel_beat(0, 0, 0, 16'h7FFF));
        send_beat(query_beat(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF));
        send_beat(query_beat(32'h80000000, 32'h80000000, 32'h80000000));
        drain();
        write_reg(CFG_ORG_X, 32'h7FFFFFFF);
        write_reg(CFG_ORG_Y, 32'h7FFFFFFF);
        write_reg(CFG_ORG_Z, 32'h7FFFFFFF);
        send_beat(query_beat(32'h80000000, 32'h80000000, 32'h80000000));
        drain();
        write_reg(CFG_SCALE_X, 0);
        send_beat(query_beat(32'h7FFFFFFF, 32'h80000000, 32'h80000000));
    endtask

    task automatic test_long_axis();
        logic [31:0] o [3];
        logic [31:0] s [3];
        int          n [3];
        for (int k = 0; k < 3; k++) begin
            n = '{1, 1, 1};
            n[k] = 64;
            for (int j = 0; j < 3; j++) begin
                o[j] = $urandom_range(0, 1 << 20) - (1 << 19);
                s[j] = $urandom_range(1 << 14, 1 << 18);
            end
            setup_grid(n[0], n[1], n[2], o, s);
            fill_grid();
            repeat (12) send_beat(query_beat(aim_axis(0), aim_axis(1), aim_axis(2)));
        end
    endtask

    task automatic test_random_phases();
        logic [31:0] o [3];
        logic [31:0] s [3];
        int          pick;
        for (int ph = 0; ph < 3; ph++) begin
            for (int j = 0; j < 3; j++) begin
                pick = $urandom_range(0, 9);
                o[j] = (pick == 0) ? $urandom : $urandom_range(0, 1 << 22) - (1 << 21);
                s[j] = (pick == 1) ? $urandom : (pick == 2) ? 0
                       : $urandom_range(1 << 13, 1 << 19);
            end
            setup_grid($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6), o, s);
            fill_grid();
            burst = ($urandom_range(0, 2) == 0);
            repeat (40) begin
                pick = $urandom_range(0, 19);
                if (pick < 2)
                    send_beat(voxel_beat($urandom_range(0, 63), $urandom_range(0, 63),
                                         $urandom_range(0, 63), $urandom));
                else if (pick < 4)
                    send_beat(voxel_beat($urandom_range(0, axis_len(0) - 1),
                                         $urandom_range(0, axis_len(1) - 1),
                                         $urandom_range(0, axis_len(2) - 1), $urandom));
                else if (pick == 4)
                    send_beat(query_beat($urandom, $urandom, $urandom));
                else
                    send_beat(query_beat(aim_axis(0), aim_axis(1), aim_axis(2)));
            end
            burst = 1'b0;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (distance_q.size() == 0) begin
                n_fail++;
                if (n_mism++ < 10) $display("unexpected beat: distance %0d", o_distance);
            end else begin
                if (o_distance !== distance_q[0]) begin
                    n_fail++;
                    if (n_mism++ < 10)
                        $display("distance mismatch: expected %0d actual %0d",
                                 distance_q[0], o_distance);
                end
                void'(distance_q.pop_front());
            end
        end
    end

    initial begin
        grid_dims = '0;
        grid_org = '{0, 0, 0};
        grid_scl = '{32'h10000, 32'h10000, 32'h10000};
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_single_voxel();
        test_full_dims();
        test_long_axis();
        test_random_phases();
        drain();
        if (n_fail == 0 && distance_q.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== sdf_grid_trilinear_sampler_core.f =====
src/sdfts_pkg.sv
src/sdfts_ram.sv
src/sdfts_axis.sv
src/sdfts_lerp.sv
src/sdf_grid_trilinear_sampler_core.sv
src/sdfts_checker.sv
tb/sv/tb_top.sv
